[rtl/core/mqae_pkg.sv]
// ----------------------------------------------------------------------------
// mqae_pkg
// Shared constants, probability tables and types of the MQ arithmetic encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mqae_pkg;

  localparam int CONTEXT_BITS = 16;
  localparam int MAX_PENDING  = 16;
  localparam int MAX_RESULTS  = 40;
  localparam int CNT_W        = $clog2(MAX_RESULTS + 1);
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int NUM_STATES   = 47;

  // command opcodes on the input channel
  localparam logic [1:0] OP_ENCODE  = 2'd0;
  localparam logic [1:0] OP_FLUSH   = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [7:0] BYTE_FF   = 8'hff;
  localparam logic [7:0] BYTE_7F   = 8'h7f;
  localparam logic [7:0] BYTE_TERM = 8'hac;

  // qe probability per state
  localparam logic [15:0] QE_TAB [NUM_STATES] = '{
    16'h5601, 16'h3401, 16'h1801, 16'h0AC1, 16'h0521, 16'h0221, 16'h5601, 16'h5401,
    16'h4801, 16'h3801, 16'h3001, 16'h2401, 16'h1C01, 16'h1601, 16'h5601, 16'h5401,
    16'h5101, 16'h4801, 16'h3801, 16'h3401, 16'h3001, 16'h2801, 16'h2401, 16'h2201,
    16'h1C01, 16'h1801, 16'h1601, 16'h1401, 16'h1201, 16'h1101, 16'h0AC1, 16'h09C1,
    16'h08A1, 16'h0521, 16'h0441, 16'h02A1, 16'h0221, 16'h0141, 16'h0111, 16'h0085,
    16'h0049, 16'h0025, 16'h0015, 16'h0009, 16'h0005, 16'h0001, 16'h5601
  };

  localparam logic [5:0] NMPS_TAB [NUM_STATES] = '{
    6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd38, 6'd7,  6'd8,  6'd9,  6'd10, 6'd11, 6'd12,
    6'd13, 6'd29, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24,
    6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36,
    6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd45, 6'd46
  };

  localparam logic [5:0] NLPS_TAB [NUM_STATES] = '{
    6'd1,  6'd6,  6'd9,  6'd12, 6'd29, 6'd33, 6'd6,  6'd14, 6'd14, 6'd14, 6'd17, 6'd18,
    6'd20, 6'd21, 6'd14, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd19, 6'd20, 6'd21,
    6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33,
    6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd46
  };

  localparam logic SWITCH_TAB [NUM_STATES] = '{
    1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
  };

  // work handed from front to back
  typedef enum logic [1:0] {
    CMD_ENC,
    CMD_FLUSH,
    CMD_RESTART
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] val;     // qe to add to c, or interval for flush
    logic [3:0]  nshift;  // renormalization shifts
  } qent_t;

  typedef enum logic [1:0] {
    F_CLEAR,
    F_IDLE,
    F_CALC
  } fstate_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SHIFT,
    B_BYTEOUT,
    B_SEND,
    B_RUN,
    B_TAIL,
    B_DONE,
    B_RD,
    B_OUT
  } bstate_t;

endpackage

`default_nettype wire

[rtl/core/mqae_intf.sv]
// ----------------------------------------------------------------------------
// mqae channel interfaces
// Valid/ready channels for command beats and code byte beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface mqae_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] context_index;
  logic        symbol_bit;
  modport source (output valid, opcode, context_index, symbol_bit, input ready);
  modport sink   (input valid, opcode, context_index, symbol_bit, output ready);
endinterface

interface mqae_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last;
  logic       overflow;
  modport source (output valid, code_byte, last, overflow, input ready);
  modport sink   (input valid, code_byte, last, overflow, output ready);
endinterface

`default_nettype wire

[rtl/core/mqae_queue.sv]
// ----------------------------------------------------------------------------
// mqae_queue
// Short command queue between the context front end and the coder back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mqae_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire mqae_pkg::qent_t push_data,
  input  wire logic            pop,
  output mqae_pkg::qent_t      head,
  output logic                 empty,
  output logic                 full
);

  mqae_pkg::qent_t                  ent_r [mqae_pkg::QDEPTH];
  logic [mqae_pkg::QPTR_W-1:0]      wp_r, rp_r;
  logic [mqae_pkg::QPTR_W:0]        cnt_r;

  assign head  = ent_r[rp_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (mqae_pkg::QPTR_W+1)'(mqae_pkg::QDEPTH));

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (mqae_pkg::QPTR_W+1)'(push) - (mqae_pkg::QPTR_W+1)'(pop);
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop) else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue pop while empty");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (mqae_pkg::QPTR_W+1)'(mqae_pkg::QDEPTH)) else $error("queue level range");

endmodule

`default_nettype wire

[rtl/core/mqae_front.sv]
// ----------------------------------------------------------------------------
// mqae_front
// Context memory, probability adaptation and interval register.
// ----------------------------------------------------------------------------
`default_nettype none

module mqae_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  mqae_in_if.sink              in_ch,
  input  wire logic            q_full,
  output logic                 q_push,
  output mqae_pkg::qent_t      q_data
);

  localparam int CB = mqae_pkg::CONTEXT_BITS;

  mqae_pkg::fstate_t st_r, st_nxt;
  logic [CB-1:0]     clr_r;
  logic [15:0]       a_r, a_nxt;
  logic [1:0]        op_r;
  logic [CB-1:0]     cx_r;
  logic              bit_r;
  logic [6:0]        rd_r;
  logic [6:0]        ctx_mem [2**CB];

  logic              mem_we;
  logic [CB-1:0]     mem_wa;
  logic [6:0]        mem_wd;
  logic              accept;

  // leading zeros of a nonzero interval
  function automatic logic [3:0] lead_zeros(input logic [15:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) n = 4'(15 - i);
    end
    return n;
  endfunction

  assign in_ch.ready = (st_r == mqae_pkg::F_IDLE) && !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      mqae_pkg::F_CLEAR: if (&clr_r) st_nxt = mqae_pkg::F_IDLE;
      mqae_pkg::F_IDLE:  if (accept) st_nxt = mqae_pkg::F_CALC;
      mqae_pkg::F_CALC:  st_nxt = mqae_pkg::F_IDLE;
      default:           st_nxt = mqae_pkg::F_IDLE;
    endcase
  end

  // context update and command classification
  always_comb begin
    logic [5:0]  ss;
    logic        mps;
    logic [15:0] q;
    logic [15:0] asub;
    logic [15:0] anew;
    logic [15:0] addq;
    logic        renorm;
    logic [3:0]  ns;
    a_nxt  = a_r;
    q_push = 1'b0;
    q_data = '{cmd: mqae_pkg::CMD_ENC, val: '0, nshift: '0};
    mem_we = 1'b0;
    mem_wa = clr_r;
    mem_wd = '0;
    ss     = (rd_r[5:0] > 6'd46) ? 6'd46 : rd_r[5:0];
    mps    = rd_r[6];
    q      = mqae_pkg::QE_TAB[ss];
    asub   = a_r - q;
    anew   = asub;
    addq   = '0;
    renorm = 1'b0;
    ns     = '0;
    case (st_r)
      mqae_pkg::F_CLEAR: begin
        mem_we = 1'b1;
      end
      mqae_pkg::F_CALC: begin
        case (op_r)
          mqae_pkg::OP_ENCODE: begin
            if (bit_r != mps) begin
              // less probable symbol
              if (asub < q) begin
                addq = q;
              end else begin
                anew = q;
              end
              if (mqae_pkg::SWITCH_TAB[ss]) mps = ~mps;
              ss     = mqae_pkg::NLPS_TAB[ss];
              renorm = 1'b1;
            end else if (!asub[15]) begin
              // more probable symbol with renormalization and conditional exchange
              if (asub < q) begin
                anew = q;
              end else begin
                addq = q;
              end
              ss     = mqae_pkg::NMPS_TAB[ss];
              renorm = 1'b1;
            end else begin
              addq = q;
            end
            if (renorm) ns = lead_zeros(anew);
            a_nxt  = anew << ns;
            mem_we = 1'b1;
            mem_wa = cx_r;
            mem_wd = {mps, ss};
            q_push = 1'b1;
            q_data = '{cmd: mqae_pkg::CMD_ENC, val: addq, nshift: ns};
          end
          mqae_pkg::OP_FLUSH: begin
            q_push = 1'b1;
            q_data = '{cmd: mqae_pkg::CMD_FLUSH, val: a_r, nshift: '0};
          end
          mqae_pkg::OP_RESTART: begin
            a_nxt  = 16'h8000;
            q_push = 1'b1;
            q_data = '{cmd: mqae_pkg::CMD_RESTART, val: '0, nshift: '0};
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // context memory
  always_ff @(posedge clk) begin
    if (mem_we) ctx_mem[mem_wa] <= mem_wd;
    if (accept) rd_r <= ctx_mem[CB'(in_ch.context_index)];
  end

  // captured command
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_ch.opcode;
      cx_r  <= CB'(in_ch.context_index);
      bit_r <= in_ch.symbol_bit;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= mqae_pkg::F_CLEAR;
      clr_r <= '0;
      a_r   <= 16'h8000;
    end else begin
      st_r <= st_nxt;
      a_r  <= a_nxt;
      if (st_r == mqae_pkg::F_CLEAR) clr_r <= clr_r + 1'b1;
    end
  end

  a_interval_norm: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == mqae_pkg::F_IDLE |-> a_r[15]) else $error("interval not normalized");
  a_push_calc: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> st_r == mqae_pkg::F_CALC) else $error("push outside calc");
  a_calc_once: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == mqae_pkg::F_CALC |=> st_r == mqae_pkg::F_IDLE) else $error("calc not one cycle");

endmodule

`default_nettype wire

[rtl/core/mqae_back.sv]
// ----------------------------------------------------------------------------
// mqae_back
// Code register, renormalization, byte out with carry, held runs and beats.
// ----------------------------------------------------------------------------
`default_nettype none

module mqae_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire mqae_pkg::qent_t head,
  input  wire logic            q_empty,
  output logic                 q_pop,
  mqae_out_if.source           out_ch
);

  localparam int CW = mqae_pkg::CNT_W;

  mqae_pkg::bstate_t st_r, st_nxt, ret_st;
  logic [27:0] c_r, c_nxt;
  logic [3:0]  ct_r, ct_nxt;
  logic [7:0]  bb_r, bb_nxt;
  logic        first_r, first_nxt;
  logic        final_r, final_nxt;
  logic [4:0]  pff_r, pff_nxt;
  logic [4:0]  p7f_r, p7f_nxt;
  logic        ovf_r, ovf_nxt;
  logic [3:0]  n_r, n_nxt;
  logic        fl_r, fl_nxt;
  logic [1:0]  fp_r, fp_nxt;
  logic [7:0]  sb_r, sb_nxt;
  logic        ph_r, ph_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic [7:0]  rdata_r;
  logic [7:0]  res_mem [mqae_pkg::MAX_RESULTS];

  logic        emit_en;
  logic [7:0]  emit_byte;
  logic        hold;
  logic        run_more;
  logic        is_last;

  assign hold = ((sb_r == mqae_pkg::BYTE_7F) && ({1'b0, p7f_r} + 6'd1 == {1'b0, pff_r})) ||
                ((sb_r == mqae_pkg::BYTE_FF) && (pff_r == p7f_r));
  assign run_more = (ph_r && p7f_r != '0) || (pff_r != '0);
  assign is_last  = (rd_idx_r == cnt_r - 1'b1);

  assign out_ch.valid     = (st_r == mqae_pkg::B_OUT);
  assign out_ch.code_byte = rdata_r;
  assign out_ch.last      = is_last;
  assign out_ch.overflow  = ovf_r;

  // where a byte send returns to
  always_comb begin
    if (fl_r) begin
      case (fp_r)
        2'd3:    ret_st = mqae_pkg::B_TAIL;
        2'd2:    ret_st = mqae_pkg::B_SEND;
        default: ret_st = mqae_pkg::B_BYTEOUT;
      endcase
    end else begin
      ret_st = (n_r != '0) ? mqae_pkg::B_SHIFT : mqae_pkg::B_DONE;
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      mqae_pkg::B_IDLE: begin
        if (!q_empty) begin
          case (head.cmd)
            mqae_pkg::CMD_ENC:
              st_nxt = (head.nshift == '0) ? mqae_pkg::B_DONE : mqae_pkg::B_SHIFT;
            mqae_pkg::CMD_FLUSH: st_nxt = mqae_pkg::B_BYTEOUT;
            default:             st_nxt = mqae_pkg::B_IDLE;
          endcase
        end
      end
      mqae_pkg::B_SHIFT: begin
        if (ct_r == 4'd1)      st_nxt = mqae_pkg::B_BYTEOUT;
        else if (n_r == 4'd1)  st_nxt = mqae_pkg::B_DONE;
      end
      mqae_pkg::B_BYTEOUT: st_nxt = mqae_pkg::B_SEND;
      mqae_pkg::B_SEND: begin
        if (!first_r && !hold && pff_r != '0) st_nxt = mqae_pkg::B_RUN;
        else                                  st_nxt = ret_st;
      end
      mqae_pkg::B_RUN:  if (!run_more) st_nxt = ret_st;
      mqae_pkg::B_TAIL: st_nxt = mqae_pkg::B_DONE;
      mqae_pkg::B_DONE: st_nxt = (cnt_r == '0) ? mqae_pkg::B_IDLE : mqae_pkg::B_RD;
      mqae_pkg::B_RD:   st_nxt = mqae_pkg::B_OUT;
      mqae_pkg::B_OUT: begin
        if (out_ch.ready) st_nxt = is_last ? mqae_pkg::B_IDLE : mqae_pkg::B_RD;
      end
      default: st_nxt = mqae_pkg::B_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    logic        do_ret;
    logic        stuff;
    logic [7:0]  bbv;
    logic [27:0] cv;
    logic [28:0] limit;
    c_nxt      = c_r;
    ct_nxt     = ct_r;
    bb_nxt     = bb_r;
    first_nxt  = first_r;
    final_nxt  = final_r;
    pff_nxt    = pff_r;
    p7f_nxt    = p7f_r;
    ovf_nxt    = ovf_r;
    n_nxt      = n_r;
    fl_nxt     = fl_r;
    fp_nxt     = fp_r;
    sb_nxt     = sb_r;
    ph_nxt     = ph_r;
    cnt_nxt    = cnt_r;
    rd_idx_nxt = rd_idx_r;
    q_pop      = 1'b0;
    emit_en    = 1'b0;
    emit_byte  = '0;
    do_ret     = 1'b0;
    stuff      = 1'b0;
    bbv        = bb_r;
    cv         = c_r;
    limit      = {1'b0, c_r} + 29'(head.val);
    case (st_r)
      mqae_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cnt_nxt = '0;
          case (head.cmd)
            mqae_pkg::CMD_ENC: begin
              c_nxt  = c_r + 28'(head.val);
              n_nxt  = head.nshift;
              fl_nxt = 1'b0;
            end
            mqae_pkg::CMD_FLUSH: begin
              // setbits then first shift
              cv = c_r | 28'h000ffff;
              if ({1'b0, cv} >= limit) cv = cv - 28'h0008000;
              c_nxt  = cv << ct_r;
              fl_nxt = 1'b1;
              fp_nxt = 2'd0;
            end
            mqae_pkg::CMD_RESTART: begin
              c_nxt     = '0;
              ct_nxt    = 4'd12;
              bb_nxt    = '0;
              first_nxt = 1'b1;
              final_nxt = 1'b0;
              pff_nxt   = '0;
              p7f_nxt   = '0;
              ovf_nxt   = 1'b0;
            end
            default: ;
          endcase
        end
      end
      mqae_pkg::B_SHIFT: begin
        c_nxt  = c_r << 1;
        ct_nxt = ct_r - 1'b1;
        n_nxt  = n_r - 1'b1;
      end
      mqae_pkg::B_BYTEOUT: begin
        // carry into buffer and stuffing decision
        if (bb_r == mqae_pkg::BYTE_FF) begin
          stuff = 1'b1;
        end else if (c_r[27]) begin
          bbv = bb_r + 1'b1;
          if (bbv == mqae_pkg::BYTE_FF) begin
            cv[27] = 1'b0;
            stuff  = 1'b1;
          end
        end
        sb_nxt = bbv;
        ph_nxt = 1'b0;
        if (stuff) begin
          bb_nxt = cv[27:20];
          c_nxt  = {8'd0, cv[19:0]};
          ct_nxt = 4'd7;
        end else begin
          bb_nxt = cv[26:19];
          c_nxt  = {9'd0, cv[18:0]};
          ct_nxt = 4'd8;
        end
      end
      mqae_pkg::B_SEND: begin
        if (first_r) begin
          first_nxt = 1'b0;
          do_ret    = 1'b1;
        end else if (hold) begin
          if (sb_r == mqae_pkg::BYTE_7F) begin
            if (p7f_r >= 5'(mqae_pkg::MAX_PENDING)) ovf_nxt = 1'b1;
            else                                    p7f_nxt = p7f_r + 1'b1;
          end else begin
            if (pff_r >= 5'(mqae_pkg::MAX_PENDING)) ovf_nxt = 1'b1;
            else                                    pff_nxt = pff_r + 1'b1;
          end
          if (final_r) begin
            emit_en   = 1'b1;
            emit_byte = mqae_pkg::BYTE_FF;
          end
          do_ret = 1'b1;
        end else if (pff_r == '0) begin
          emit_en   = 1'b1;
          emit_byte = sb_r;
          do_ret    = 1'b1;
        end
      end
      mqae_pkg::B_RUN: begin
        // held run as ff,7f pairs then the byte
        emit_en = 1'b1;
        if (ph_r && p7f_r != '0) begin
          emit_byte = mqae_pkg::BYTE_7F;
          p7f_nxt   = p7f_r - 1'b1;
          ph_nxt    = 1'b0;
        end else if (pff_r != '0) begin
          emit_byte = mqae_pkg::BYTE_FF;
          pff_nxt   = pff_r - 1'b1;
          ph_nxt    = 1'b1;
        end else begin
          emit_byte = sb_r;
          ph_nxt    = 1'b0;
          do_ret    = 1'b1;
        end
      end
      mqae_pkg::B_TAIL: begin
        emit_en   = 1'b1;
        emit_byte = mqae_pkg::BYTE_TERM;
      end
      mqae_pkg::B_DONE: begin
        rd_idx_nxt = '0;
      end
      mqae_pkg::B_OUT: begin
        if (out_ch.ready) rd_idx_nxt = rd_idx_r + 1'b1;
      end
      default: ;
    endcase

    // flush sequencing after each send
    if (do_ret && fl_r) begin
      case (fp_r)
        2'd0, 2'd1: begin
          c_nxt  = (c_r | 28'h0007fff) << ct_r;
          fp_nxt = fp_r + 1'b1;
        end
        2'd2: begin
          final_nxt = 1'b1;
          sb_nxt    = bb_r;
          fp_nxt    = 2'd3;
        end
        default: ;
      endcase
    end

    // result buffer fill
    if (emit_en) begin
      if (cnt_r < CW'(mqae_pkg::MAX_RESULTS)) cnt_nxt = cnt_r + 1'b1;
      else                                    ovf_nxt = 1'b1;
    end
  end

  // result buffer
  always_ff @(posedge clk) begin
    if (emit_en && cnt_r < CW'(mqae_pkg::MAX_RESULTS)) res_mem[cnt_r] <= emit_byte;
    if (st_r == mqae_pkg::B_RD) rdata_r <= res_mem[rd_idx_r];
  end

  // payload registers
  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    sb_r     <= sb_nxt;
    rd_idx_r <= rd_idx_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= mqae_pkg::B_IDLE;
      c_r     <= '0;
      ct_r    <= 4'd12;
      bb_r    <= '0;
      first_r <= 1'b1;
      final_r <= 1'b0;
      pff_r   <= '0;
      p7f_r   <= '0;
      ovf_r   <= 1'b0;
      fl_r    <= 1'b0;
      fp_r    <= '0;
      ph_r    <= 1'b0;
      cnt_r   <= '0;
    end else begin
      st_r    <= st_nxt;
      c_r     <= c_nxt;
      ct_r    <= ct_nxt;
      bb_r    <= bb_nxt;
      first_r <= first_nxt;
      final_r <= final_nxt;
      pff_r   <= pff_nxt;
      p7f_r   <= p7f_nxt;
      ovf_r   <= ovf_nxt;
      fl_r    <= fl_nxt;
      fp_r    <= fp_nxt;
      ph_r    <= ph_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(mqae_pkg::MAX_RESULTS)) else $error("result count overrun");
  a_pend_max: assert property (@(posedge clk) disable iff (!rst_n)
    pff_r <= 5'(mqae_pkg::MAX_PENDING) && p7f_r <= 5'(mqae_pkg::MAX_PENDING))
    else $error("held run above limit");
  a_ct_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == mqae_pkg::B_IDLE |-> ct_r != '0) else $error("shift count zero at idle");
  a_out_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> cnt_r != '0 && rd_idx_r < cnt_r) else $error("beat past results");

endmodule

`default_nettype wire

[rtl/core/mq_arithmetic_encoder.sv]
// ----------------------------------------------------------------------------
// mq_arithmetic_encoder
// Context-adaptive binary MQ arithmetic encoder with held 0xff/0x7f runs.
// ----------------------------------------------------------------------------
//  channel  dir  payload                               handshake
//  in_ch    in   opcode, context_index, symbol_bit     valid/ready
//  out_ch   out  code_byte, last, overflow             valid/ready
//
//  front end takes a command, reads context memory, then writes it back;
//  no new command is taken before the write back or while the queue is full
//  back end: pop a command, renormalization shifts, byte out and send,
//  released held run bytes, finish, then result beats read from the buffer
//  after reset all 65536 context memory entries are cleared, in_ch not ready
//  a 4-entry queue lets the front end run ahead while results drain
// ----------------------------------------------------------------------------
`default_nettype none

module mq_arithmetic_encoder (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mqae_in_if.sink    in_ch,
  mqae_out_if.source out_ch
);

  logic            q_push, q_pop, q_empty, q_full;
  mqae_pkg::qent_t q_data, q_head;

  // context and interval side
  mqae_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  // command queue
  mqae_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // code register and byte side
  mqae_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
